### rtl/wet_pkg.sv
// ----------------------------------------------------------------------------
// wet_pkg
// Shared types and constants for the weighted edge table.
// ----------------------------------------------------------------------------
package wet_pkg;

  localparam int EDGE_DEPTH = 64;
  localparam int IDX_W      = $clog2(EDGE_DEPTH);
  localparam int CNT_W      = $clog2(EDGE_DEPTH + 1);
  localparam int NODE_W     = 32;
  localparam int REL_W      = 8;
  localparam int WGT_W      = 32;
  localparam int FAC_W      = 16;
  localparam int KEY_W      = 2 * NODE_W + REL_W;
  localparam int PROD_W     = WGT_W + FAC_W + 1;
  localparam int FRAC_SH    = 15;

  localparam logic [REL_W-1:0] ANY_RELATION = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_NEIGH = 2'd2,
    OP_DECAY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

### rtl/weighted_edge_table.sv
// ----------------------------------------------------------------------------
// weighted_edge_table
// Bounded insertion-ordered table of weighted edges with add, read,
// neighbour listing and decay.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. Every operation walks the stored
// entries in insertion order, one entry per cycle through the read port of
// the key and weight RAMs while the scan is not held; add and read stop early
// at the first match, and a neighbour listing also waits for each of its
// results to be taken. The RAMs need no clearing pass after reset: only
// entries below the fill count are ever read. in_ready is high only while no
// operation is in progress.
module weighted_edge_table import wet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [NODE_W-1:0]        node_a,
  input  logic [NODE_W-1:0]        node_b,
  input  logic [REL_W-1:0]         relation,
  input  logic signed [WGT_W-1:0]  increment,
  input  logic [FAC_W-1:0]         decay_factor,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [WGT_W-1:0]  weight,
  output logic [NODE_W-1:0]        neighbor_id,
  output logic                     last
);

  localparam logic signed [WGT_W-1:0] W_MAX = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic signed [WGT_W-1:0] W_MIN = {1'b1, {(WGT_W-1){1'b0}}};

  state_t state, state_next;

  // latched transaction
  op_t                     op;
  logic [NODE_W-1:0]       qa;
  logic [NODE_W-1:0]       qb;
  logic [REL_W-1:0]        qrel;
  logic signed [WGT_W-1:0] qinc;
  logic [FAC_W-1:0]        qfac;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             prod_valid;
  logic [IDX_W-1:0] prod_idx;
  logic signed [PROD_W-1:0] prod;
  logic              pend_valid;
  logic [NODE_W-1:0] pend_id;

  status_t           out_status;

  // RAM ports
  logic [KEY_W-1:0]        key_q;
  logic signed [WGT_W-1:0] w_q;
  logic                    rd_en;
  logic                    k_we;
  logic                    w_we;
  logic [IDX_W-1:0]        w_waddr;
  logic signed [WGT_W-1:0] w_wdata;

  // datapath
  logic [NODE_W-1:0]       e_src, e_dst;
  logic [REL_W-1:0]        e_rel;
  logic                    key_hit, nb_hit, nb_src;
  logic [NODE_W-1:0]       nb_id;
  logic [WGT_W:0]          sum;
  logic signed [WGT_W-1:0] sat_sum;
  logic signed [PROD_W-1:0] rnd;
  logic [PROD_W-FRAC_SH-1:0] qdec;
  logic signed [WGT_W-1:0] dec_w;
  logic                    can_emit, scan_more, scan_done, found, has_room;

  // controls
  logic                    advance, emit, emit_last, pend_load, count_inc;
  status_t                 emit_status;
  logic signed [WGT_W-1:0] emit_weight;
  logic [NODE_W-1:0]       emit_nb;

  wet_ram #(.WIDTH(KEY_W), .DEPTH(EDGE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({qa, qb, qrel}),
    .re    (rd_en),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (key_q)
  );

  wet_ram #(.WIDTH(WGT_W), .DEPTH(EDGE_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (rd_en),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (w_q)
  );

  assign e_src = key_q[KEY_W-1 -: NODE_W];
  assign e_dst = key_q[REL_W +: NODE_W];
  assign e_rel = key_q[REL_W-1:0];

  assign key_hit = (e_src == qa) && (e_dst == qb) && (e_rel == qrel);
  assign nb_src  = (e_src == qa);
  assign nb_hit  = ((qrel == ANY_RELATION) || (e_rel == qrel)) && (nb_src || (e_dst == qa));
  assign nb_id   = nb_src ? e_dst : e_src;

  assign sum     = {w_q[WGT_W-1], w_q} + {qinc[WGT_W-1], qinc};
  assign sat_sum = (sum[WGT_W] != sum[WGT_W-1]) ? (sum[WGT_W] ? W_MIN : W_MAX)
                                                : $signed(sum[WGT_W-1:0]);

  // floor((w * f + 2^14) / 2^15), saturated
  assign rnd   = prod + PROD_W'(16384);
  assign qdec  = rnd[PROD_W-1:FRAC_SH];
  assign dec_w = (qdec[PROD_W-FRAC_SH-1:WGT_W-1] == '0 ||
                  qdec[PROD_W-FRAC_SH-1:WGT_W-1] == '1)
                 ? $signed(qdec[WGT_W-1:0])
                 : (qdec[PROD_W-FRAC_SH-1] ? W_MIN : W_MAX);

  assign can_emit  = !out_valid || out_ready;
  assign scan_more = (scan_idx < count);
  assign scan_done = !chk_valid && !scan_more && !prod_valid;
  assign found     = chk_valid && key_hit;
  assign has_room  = (count < CNT_W'(EDGE_DEPTH));
  assign in_ready  = (state == S_IDLE);
  assign rd_en     = (state == S_SCAN) && advance && scan_more;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if ((op == OP_ADD || op == OP_READ) && found) begin
          if (can_emit) state_next = S_IDLE;
        end else if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    advance     = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_weight = '0;
    emit_nb     = '0;
    emit_last   = 1'b1;
    pend_load   = 1'b0;
    count_inc   = 1'b0;
    k_we        = 1'b0;
    w_we        = 1'b0;
    w_waddr     = chk_idx;
    w_wdata     = sat_sum;
    unique case (state)
      S_IDLE: ;
      S_SCAN: begin
        case (op) inside
          OP_ADD, OP_READ: begin
            advance     = !found;
            emit        = found && can_emit;
            emit_weight = (op == OP_ADD) ? sat_sum : w_q;
            w_we        = (op == OP_ADD) && found && can_emit;
          end
          OP_NEIGH: begin
            advance     = !(chk_valid && nb_hit && pend_valid && !can_emit);
            emit        = chk_valid && nb_hit && pend_valid && can_emit;
            emit_nb     = pend_id;
            emit_last   = 1'b0;
            pend_load   = chk_valid && nb_hit && advance;
          end
          default: begin
            advance = 1'b1;
            w_we    = prod_valid;
            w_waddr = prod_idx;
            w_wdata = dec_w;
          end
        endcase
      end
      S_FINISH: begin
        emit = can_emit;
        case (op)
          OP_ADD: begin
            emit_status = has_room ? ST_INSERTED : ST_FULL;
            emit_weight = has_room ? qinc : '0;
            count_inc   = can_emit && has_room;
            k_we        = count_inc;
            w_we        = count_inc;
            w_waddr     = count[IDX_W-1:0];
            w_wdata     = qinc;
          end
          OP_READ: emit_status = ST_NONE;
          OP_NEIGH: begin
            emit_status = pend_valid ? ST_OK : ST_NONE;
            emit_nb     = pend_valid ? pend_id : '0;
          end
          default: emit_status = ST_OK;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      chk_valid  <= 1'b0;
      prod_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) count <= count + 1'b1;
      if (in_valid && in_ready) begin
        chk_valid  <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == S_SCAN && advance) begin
        chk_valid <= scan_more;
      end
      prod_valid <= (state == S_SCAN) && (op == OP_DECAY) && chk_valid;
      if (pend_load) pend_valid <= 1'b1;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op       <= op_t'(operation);
      qa       <= node_a;
      qb       <= node_b;
      qrel     <= relation;
      qinc     <= increment;
      qfac     <= decay_factor;
      scan_idx <= '0;
    end else if (state == S_SCAN && advance) begin
      chk_idx <= scan_idx[IDX_W-1:0];
      if (scan_more) scan_idx <= scan_idx + 1'b1;
    end
    prod     <= PROD_W'(w_q) * $signed({1'b0, qfac});
    prod_idx <= chk_idx;
    if (pend_load) pend_id <= nb_id;
    if (emit) begin
      out_status  <= emit_status;
      weight      <= emit_weight;
      neighbor_id <= emit_nb;
      last        <= emit_last;
    end
  end

  assign status = out_status;

endmodule

### rtl/wet_ram.sv
// ----------------------------------------------------------------------------
// wet_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/wet_checker.sv
// ----------------------------------------------------------------------------
// wet_checker
// Port-level checks on the weighted edge table, bound to the top level.
// ----------------------------------------------------------------------------
module wet_checker import wet_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic signed [WGT_W-1:0] weight,
  input logic [NODE_W-1:0]       neighbor_id,
  input logic                    last
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(weight)
      && $stable(neighbor_id) && $stable(last))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a transaction stays open until its final result
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input accepted before final result");

  // add outcomes are single results with no neighbour
  a_add_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_FULL)
      |-> last && neighbor_id == '0)
    else $error("add result malformed");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> weight == '0)
    else $error("table full with non-zero weight");

endmodule

bind weighted_edge_table wet_checker u_wet_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .weight      (weight),
  .neighbor_id (neighbor_id),
  .last        (last)
);

### verif/weighted_edge_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_edge_table_checker
// Watches both channels of the weighted edge table, keeps its own copy of the
// edge table, works out the results of every accepted transaction and
// compares each result transaction field by field, oldest first.
// ----------------------------------------------------------------------------
module weighted_edge_table_checker import wet_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              operation,
  input  logic [NODE_W-1:0]       node_a,
  input  logic [NODE_W-1:0]       node_b,
  input  logic [REL_W-1:0]        relation,
  input  logic signed [WGT_W-1:0] increment,
  input  logic [FAC_W-1:0]        decay_factor,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              status,
  input  logic signed [WGT_W-1:0] weight,
  input  logic [NODE_W-1:0]       neighbor_id,
  input  logic                    last,
  output int                      errors,
  output int                      accepted_items,
  output int                      outstanding,
  output int                      checked_results
);

  typedef struct packed {
    status_t                 status;
    logic signed [WGT_W-1:0] weight;
    logic [NODE_W-1:0]       neighbor;
    logic                    last;
  } edge_result_t;

  localparam logic signed [63:0] WGT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WGT_MIN = -64'sh0000_0000_8000_0000;

  logic [NODE_W-1:0]       edge_src [EDGE_DEPTH];
  logic [NODE_W-1:0]       edge_dst [EDGE_DEPTH];
  logic [REL_W-1:0]        edge_rel [EDGE_DEPTH];
  logic signed [WGT_W-1:0] edge_wgt [EDGE_DEPTH];
  int                      edge_fill;
  edge_result_t            awaited_results [$];
  edge_result_t            oldest;

  function automatic logic signed [WGT_W-1:0] clamp_weight(input logic signed [63:0] v);
    if (v > WGT_MAX) return WGT_MAX[WGT_W-1:0];
    if (v < WGT_MIN) return WGT_MIN[WGT_W-1:0];
    return v[WGT_W-1:0];
  endfunction

  // round to nearest, ties upward: floor((w * f + 2^14) / 2^15)
  function automatic logic signed [WGT_W-1:0] decayed_weight(
    input logic signed [WGT_W-1:0] w,
    input logic [FAC_W-1:0]        f
  );
    logic signed [63:0] p;
    p = 64'(w);
    p = p * $signed({48'd0, f}) + 64'sd16384;
    return clamp_weight(p >>> FRAC_SH);
  endfunction

  function automatic int find_edge(
    input logic [NODE_W-1:0] a,
    input logic [NODE_W-1:0] b,
    input logic [REL_W-1:0]  rel
  );
    for (int i = 0; i < edge_fill; i++) begin
      if (edge_src[i] == a && edge_dst[i] == b && edge_rel[i] == rel) return i;
    end
    return -1;
  endfunction

  function automatic void queue_result(
    input status_t                 st,
    input logic signed [WGT_W-1:0] w,
    input logic [NODE_W-1:0]       nb,
    input logic                    fin
  );
    edge_result_t r;
    r.status   = st;
    r.weight   = w;
    r.neighbor = nb;
    r.last     = fin;
    awaited_results = {awaited_results, r};
    outstanding++;
  endfunction

  function automatic void apply_transaction(
    input op_t                     op,
    input logic [NODE_W-1:0]       a,
    input logic [NODE_W-1:0]       b,
    input logic [REL_W-1:0]        rel,
    input logic signed [WGT_W-1:0] inc,
    input logic [FAC_W-1:0]        fac
  );
    int                 idx;
    logic signed [63:0] total;
    logic [NODE_W-1:0]  touching [$];
    case (op)
      OP_ADD: begin
        idx = find_edge(a, b, rel);
        if (idx >= 0) begin
          total = 64'(edge_wgt[idx]);
          total = total + inc;
          edge_wgt[idx] = clamp_weight(total);
          queue_result(ST_OK, edge_wgt[idx], '0, 1'b1);
        end else if (edge_fill < EDGE_DEPTH) begin
          edge_src[edge_fill] = a;
          edge_dst[edge_fill] = b;
          edge_rel[edge_fill] = rel;
          edge_wgt[edge_fill] = inc;
          edge_fill++;
          queue_result(ST_INSERTED, inc, '0, 1'b1);
        end else begin
          queue_result(ST_FULL, '0, '0, 1'b1);
        end
      end
      OP_READ: begin
        idx = find_edge(a, b, rel);
        if (idx >= 0) queue_result(ST_OK, edge_wgt[idx], '0, 1'b1);
        else queue_result(ST_NONE, '0, '0, 1'b1);
      end
      OP_NEIGH: begin
        for (int i = 0; i < edge_fill; i++) begin
          if (rel == ANY_RELATION || edge_rel[i] == rel) begin
            if (edge_src[i] == a) touching = {touching, edge_dst[i]};
            else if (edge_dst[i] == a) touching = {touching, edge_src[i]};
          end
        end
        if (touching.size() == 0) queue_result(ST_NONE, '0, '0, 1'b1);
        else foreach (touching[k]) queue_result(ST_OK, '0, touching[k], k == touching.size() - 1);
      end
      default: begin
        for (int i = 0; i < edge_fill; i++) edge_wgt[i] = decayed_weight(edge_wgt[i], fac);
        queue_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      edge_fill = 0;
      awaited_results.delete();
      outstanding = 0;
      accepted_items = 0;
      checked_results = 0;
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, status %0d weight 0x%0h neighbour 0x%0h last %0b",
                   $time, status, weight, neighbor_id, last);
        end else begin
          oldest = awaited_results.pop_front();
          outstanding--;
          checked_results++;
          compare_field("status", 32'(oldest.status), 32'(status));
          compare_field("weight", oldest.weight, weight);
          compare_field("neighbor_id", oldest.neighbor, neighbor_id);
          compare_field("last", 32'(oldest.last), 32'(last));
        end
      end
      if (in_valid && in_ready) begin
        apply_transaction(op_t'(operation), node_a, node_b, relation, increment, decay_factor);
        accepted_items++;
      end
    end
  end

endmodule

### verif/weighted_edge_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_edge_table_tb
// Drives add, read, neighbour and decay transactions into the weighted edge
// table: a directed opening on edge values and special cases, random traffic
// over a small node pool, a burst that fills the table past capacity, and
// random traffic under a long output hold-off. Checking is in the checker.
// ----------------------------------------------------------------------------
module weighted_edge_table_tb;
  import wet_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 100;
  localparam int MIXED_ITEMS     = 40;
  localparam int FILL_ITEMS      = 68;

  typedef enum int {
    ALWAYS_READY,
    HALF_READY,
    QUARTER_READY,
    ALTERNATE
  } stall_mode_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [1:0]              operation    = OP_ADD;
  logic [NODE_W-1:0]       node_a       = '0;
  logic [NODE_W-1:0]       node_b       = '0;
  logic [REL_W-1:0]        relation     = '0;
  logic signed [WGT_W-1:0] increment    = '0;
  logic [FAC_W-1:0]        decay_factor = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [1:0]              status;
  logic signed [WGT_W-1:0] weight;
  logic [NODE_W-1:0]       neighbor_id;
  logic                    last;

  int                errors, accepted_items, outstanding, checked_results;
  int                sent_items = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                op_count [4] = '{0, 0, 0, 0};
  logic              long_hold = 1'b0;
  logic [NODE_W-1:0] node_pool [6];
  logic [REL_W-1:0]  rel_pool [5] = '{8'h00, 8'h01, 8'h80, 8'hFE, 8'hFF};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  weighted_edge_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .node_a(node_a), .node_b(node_b), .relation(relation),
    .increment(increment), .decay_factor(decay_factor),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .weight(weight), .neighbor_id(neighbor_id), .last(last)
  );

  weighted_edge_table_checker edge_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .node_a(node_a), .node_b(node_b), .relation(relation),
    .increment(increment), .decay_factor(decay_factor),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .weight(weight), .neighbor_id(neighbor_id), .last(last),
    .errors(errors), .accepted_items(accepted_items), .outstanding(outstanding),
    .checked_results(checked_results)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("weighted_edge_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stretches of differing stall patterns, one long hold-off
  initial begin
    stall_mode_t mode;
    int          span;
    bit          held;
    held = 1'b0;
    wait (!rst);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        if (long_hold && !held) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        case (mode)
          ALWAYS_READY:  out_ready <= 1'b1;
          HALF_READY:    out_ready <= 1'($urandom_range(0, 1));
          QUARTER_READY: out_ready <= ($urandom_range(0, 3) == 0);
          default:       out_ready <= ~out_ready;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer_transaction(
    input op_t                     op,
    input logic [NODE_W-1:0]       a,
    input logic [NODE_W-1:0]       b,
    input logic [REL_W-1:0]        rel,
    input logic signed [WGT_W-1:0] inc,
    input logic [FAC_W-1:0]        fac
  );
    in_valid     <= 1'b1;
    operation    <= op;
    node_a       <= a;
    node_b       <= b;
    relation     <= rel;
    increment    <= inc;
    decay_factor <= fac;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    op_count[op]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return node_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [REL_W-1:0] pick_relation();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return rel_pool[$urandom_range(0, 4)];
  endfunction

  function automatic logic signed [WGT_W-1:0] pick_increment();
    logic signed [WGT_W-1:0] v;
    case ($urandom_range(0, 19))
      0:          v = 32'sh7FFF_FFFF;
      1:          v = 32'sh8000_0000;
      2, 3, 4, 5: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h3_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [FAC_W-1:0] pick_factor();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1, 2:    return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(16'h6000, 16'h8000));
    endcase
  endfunction

  task automatic random_transaction();
    int  dice;
    op_t op;
    dice = $urandom_range(0, 99);
    if (dice < 45) op = OP_ADD;
    else if (dice < 72) op = OP_READ;
    else if (dice < 92) op = OP_NEIGH;
    else op = OP_DECAY;
    offer_transaction(op, pick_node(), pick_node(),
                      (op == OP_NEIGH && $urandom_range(0, 1)) ? ANY_RELATION : pick_relation(),
                      pick_increment(), pick_factor());
  endtask

  initial begin
    node_pool[0] = 32'h0000_0000;
    node_pool[1] = 32'hFFFF_FFFF;
    node_pool[2] = 32'h0000_0001;
    node_pool[3] = 32'h8000_0000;
    node_pool[4] = $urandom;
    node_pool[5] = $urandom;
    burst_left = $urandom_range(0, 8);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table
    offer_transaction(OP_READ, 32'h0, 32'h0, 8'h00, $urandom, 16'($urandom));
    offer_transaction(OP_NEIGH, 32'h0, $urandom, ANY_RELATION, $urandom, 16'($urandom));
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'hFFFF);
    // saturation on both rails, self loop, extreme ids
    offer_transaction(OP_ADD, 32'h0, 32'h0, 8'h00, 32'sh7FFF_FFFF, 16'($urandom));
    offer_transaction(OP_ADD, 32'h0, 32'h0, 8'h00, 32'sh0000_0001, 16'($urandom));
    offer_transaction(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'sh8000_0000,
                      16'($urandom));
    offer_transaction(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, -32'sd1, 16'($urandom));
    offer_transaction(OP_ADD, 32'h0, 32'hFFFF_FFFF, 8'h01, 32'sh0001_8000, 16'($urandom));
    offer_transaction(OP_ADD, 32'h5, 32'h5, 8'h01, -32'sd3, 16'($urandom));
    offer_transaction(OP_ADD, 32'hFFFF_FFFF, 32'h0, 8'h00, 32'sh0000_4000, 16'($urandom));
    offer_transaction(OP_READ, 32'h0, 32'h0, 8'h00, $urandom, 16'($urandom));
    offer_transaction(OP_READ, 32'h0, 32'h0, 8'h01, $urandom, 16'($urandom));
    offer_transaction(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, $urandom, 16'($urandom));
    offer_transaction(OP_NEIGH, 32'h0, $urandom, ANY_RELATION, $urandom, 16'($urandom));
    offer_transaction(OP_NEIGH, 32'h0, $urandom, 8'h00, $urandom, 16'($urandom));
    offer_transaction(OP_NEIGH, 32'h5, $urandom, 8'h01, $urandom, 16'($urandom));
    offer_transaction(OP_NEIGH, 32'hFFFF_FFFF, $urandom, 8'h07, $urandom, 16'($urandom));
    // decay: overflow, identity, halving with ties, tiny factor, zero
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'hFFFF);
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'h8000);
    offer_transaction(OP_ADD, 32'h5, 32'h5, 8'h01, -32'sd3, 16'($urandom));
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'h4000);
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'h0001);
    offer_transaction(OP_READ, 32'h5, 32'h5, 8'h01, $urandom, 16'($urandom));
    offer_transaction(OP_DECAY, $urandom, $urandom, 8'($urandom), $urandom, 16'h0000);
    offer_transaction(OP_READ, 32'h0, 32'h0, 8'h00, $urandom, 16'($urandom));

    for (int k = 0; k < MIXED_ITEMS; k++) random_transaction();

    // let the block drain completely before the fill burst
    in_valid <= 1'b0;
    wait (accepted_items == sent_items && outstanding == 0);

    // fresh keys until the table overflows, many touching pool nodes
    for (int k = 0; k < FILL_ITEMS; k++) begin
      offer_transaction(OP_ADD, $urandom_range(0, 1) ? node_pool[$urandom_range(0, 5)] : $urandom,
                        $urandom, 8'($urandom_range(0, 255)), pick_increment(),
                        16'($urandom));
    end

    long_hold <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      offer_transaction(OP_NEIGH, node_pool[$urandom_range(0, 5)], $urandom, ANY_RELATION,
                        $urandom, 16'($urandom));
    end
    for (int k = 0; k < MIXED_ITEMS; k++) random_transaction();

    in_valid <= 1'b0;
    wait (accepted_items == sent_items && outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d transactions: %0d add, %0d read, %0d neighbour list, %0d decay",
             sent_items, op_count[OP_ADD], op_count[OP_READ], op_count[OP_NEIGH],
             op_count[OP_DECAY]);
    $display("%0d results compared, covering a full table and a long output hold-off",
             checked_results);
    if (errors == 0) begin
      $display("weighted_edge_table: match");
    end else begin
      $display("weighted_edge_table: mismatch");
    end
    $finish;
  end

endmodule
